// ===== sv/sorted_table_binary_search_assert.svh =====
// Assertion macros for the sorted key table RTL.
// Each macro samples on clk and is disabled while rst is high.
`ifndef SORTED_TABLE_BINARY_SEARCH_ASSERT_SVH
`define SORTED_TABLE_BINARY_SEARCH_ASSERT_SVH

// Same-cycle implication.
`define STBS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("stbs assertion failed");

// Next-cycle implication.
`define STBS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("stbs assertion failed");

// Invariant that holds at every edge.
`define STBS_ASSERT_ALW(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("stbs assertion failed");

`endif

// ===== sv/stbs_pkg.sv =====
// Package for the sorted key table: payload widths, command codes, result type.
// No dependencies.
`default_nettype none

package stbs_pkg;

  localparam int unsigned STBS_TABLE_DEPTH = 1024;
  localparam int unsigned KEY_W  = 32;
  localparam int unsigned FUNC_W = 2;
  localparam int unsigned POS_W  = 11;

  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd2;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             found;
    logic             table_sorted;
    logic             table_full;
  } stbs_res_t;

endpackage

`default_nettype wire

// ===== sv/stbs_req_if.sv =====
// Request channel of the sorted key table: valid/ready plus command and key.
// Depends on stbs_pkg.
`default_nettype none

interface stbs_req_if import stbs_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [FUNC_W-1:0]       func;
  logic signed [KEY_W-1:0] key_value;

  modport source (output valid, func, key_value, input ready);
  modport sink   (input valid, func, key_value, output ready);
endinterface

`default_nettype wire

// ===== sv/stbs_rsp_if.sv =====
// Response channel of the sorted key table: valid/ready plus result fields.
// Depends on stbs_pkg.
`default_nettype none

interface stbs_rsp_if import stbs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] position;
  logic             found;
  logic             table_sorted;
  logic             table_full;

  modport source (output valid, position, found, table_sorted, table_full, input ready);
  modport sink   (input valid, position, found, table_sorted, table_full, output ready);
endinterface

`default_nettype wire

// ===== sv/stbs_key_ram.sv =====
// Key store: single-port-write, single-port-read synchronous RAM with a registered read.
// Depends on stbs_pkg.
`default_nettype none

module stbs_key_ram import stbs_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = STBS_TABLE_DEPTH,
  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [KEY_W-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [KEY_W-1:0] rd_data
);

  logic [KEY_W-1:0] mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/stbs_ctrl.sv =====
// Command sequencer: decodes a request, appends keys, runs the binary search
// against the key RAM one probe at a time. Depends on stbs_pkg and stbs_req_if.
`default_nettype none
`include "sorted_table_binary_search_assert.svh"

module stbs_ctrl import stbs_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = STBS_TABLE_DEPTH,
  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  stbs_req_if.sink              req,
  output logic                  res_valid,
  output stbs_res_t             res,
  input  wire logic             res_ready,
  output logic                  wr_en,
  output logic      [AW-1:0]    wr_addr,
  output logic      [KEY_W-1:0] wr_data,
  output logic                  rd_en,
  output logic      [AW-1:0]    rd_addr,
  input  wire logic [KEY_W-1:0] rd_data
);

  localparam int unsigned EXT_W = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_CMP  = 4'b0100,
    S_HOLD = 4'b1000
  } state_t;

  state_t                  state, state_next;
  logic [CW-1:0]           count, count_next;
  logic                    ascending, ascending_next;
  logic signed [KEY_W-1:0] prev_key, prev_key_next;
  logic signed [KEY_W-1:0] key_q, key_q_next;
  logic [CW-1:0]           lo, lo_next;
  logic [CW-1:0]           hi_ex, hi_ex_next;   // one past the upper bound
  logic [AW-1:0]           mid_q, mid_q_next;
  stbs_res_t               res_q, res_q_next;

  logic                    accept;
  logic                    full;
  logic [CW-1:0]           count_inc;
  logic [CW:0]             mid_sum;
  logic [AW-1:0]           mid_rd;
  logic signed [KEY_W-1:0] probe;
  logic [CW-1:0]           mid_cw;
  logic [CW-1:0]           lo_cmp, hi_cmp;
  logic [EXT_W-1:0]        cnt_ext, inc_ext, mid_ext;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign full      = (count == CW'(TABLE_DEPTH));
  assign count_inc = count + 1'b1;

  // floor((lo + hi) / 2) with hi = hi_ex - 1; lo < hi_ex here, so no underflow
  assign mid_sum = {1'b0, lo} + {1'b0, hi_ex} - 1'b1;
  assign mid_rd  = mid_sum[AW:1];

  assign probe  = signed'(rd_data);
  assign mid_cw = CW'(mid_q);

  assign cnt_ext = EXT_W'(count);
  assign inc_ext = EXT_W'(count_inc);
  assign mid_ext = EXT_W'(mid_q);

  // Appends and probes never share a cycle: writes only in idle, reads only in S_READ.
  assign wr_en   = accept && (req.func == FUNC_APPEND) && !full;
  assign wr_addr = count[AW-1:0];
  assign wr_data = req.key_value;
  assign rd_en   = (state == S_READ);
  assign rd_addr = mid_rd;

  assign res_valid = (state == S_HOLD);
  assign res       = res_q;

  always_comb begin
    state_next     = state;
    count_next     = count;
    ascending_next = ascending;
    prev_key_next  = prev_key;
    key_q_next     = key_q;
    lo_next        = lo;
    hi_ex_next     = hi_ex;
    mid_q_next     = mid_q;
    res_q_next     = res_q;
    lo_cmp         = lo;
    hi_cmp         = hi_ex;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          key_q_next              = req.key_value;
          res_q_next.position     = cnt_ext[POS_W-1:0];
          res_q_next.found        = 1'b0;
          res_q_next.table_sorted = ascending;
          res_q_next.table_full   = 1'b0;
          state_next              = S_HOLD;
          unique case (req.func)
            FUNC_CLEAR: begin
              count_next              = '0;
              ascending_next          = 1'b1;
              prev_key_next           = '0;
              res_q_next.position     = '0;
              res_q_next.table_sorted = 1'b1;
            end
            FUNC_APPEND: begin
              if (full) begin
                res_q_next.table_full = 1'b1;
              end else begin
                count_next    = count_inc;
                prev_key_next = req.key_value;
                if ((count != '0) && (prev_key >= req.key_value)) begin
                  ascending_next          = 1'b0;
                  res_q_next.table_sorted = 1'b0;
                end
                res_q_next.position = inc_ext[POS_W-1:0];
              end
            end
            FUNC_SEARCH: begin
              // empty table answers with position zero straight away
              if (count != '0) begin
                lo_next    = '0;
                hi_ex_next = count;
                state_next = S_READ;
              end
            end
            default: begin
              // unused code: report current state only
            end
          endcase
        end
      end
      S_READ: begin
        mid_q_next = mid_rd;
        state_next = S_CMP;
      end
      S_CMP: begin
        if (probe == key_q) begin
          res_q_next.position = mid_ext[POS_W-1:0];
          res_q_next.found    = 1'b1;
          state_next          = S_HOLD;
        end else begin
          if (probe < key_q) begin
            lo_cmp = mid_cw + 1'b1;
          end else begin
            hi_cmp = mid_cw;
          end
          lo_next    = lo_cmp;
          hi_ex_next = hi_cmp;
          if (lo_cmp < hi_cmp) begin
            state_next = S_READ;
          end else begin
            res_q_next.position = cnt_ext[POS_W-1:0];
            res_q_next.found    = 1'b0;
            state_next          = S_HOLD;
          end
        end
      end
      S_HOLD: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      ascending <= 1'b1;
      prev_key  <= '0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      ascending <= ascending_next;
      prev_key  <= prev_key_next;
    end
  end

  always_ff @(posedge clk) begin
    key_q <= key_q_next;
    lo    <= lo_next;
    hi_ex <= hi_ex_next;
    mid_q <= mid_q_next;
    res_q <= res_q_next;
  end

  `STBS_ASSERT_IMP(a_read_bounds, state == S_READ, (lo < hi_ex) && (hi_ex <= count))
  `STBS_ASSERT_IMP(a_probe_in_table, state == S_CMP, mid_cw < count)
  `STBS_ASSERT_IMP(a_write_has_room, wr_en, count < CW'(TABLE_DEPTH))
  `STBS_ASSERT_ALW(a_count_bound, count <= CW'(TABLE_DEPTH))
  `STBS_ASSERT_NXT(a_clear_empties, accept && (req.func == FUNC_CLEAR), (count == '0) && ascending)

endmodule

`default_nettype wire

// ===== sv/sorted_table_binary_search.sv =====
// Sorted key table with binary search; uses stbs_pkg, the channel interfaces,
// stbs_ctrl and stbs_key_ram. Results go via the hold state into the output register.
// Search: P probes <= floor(log2(count)) + 1 (11 at depth 1024); each probe is one
// key RAM read plus a compare. New requests wait until the last result is registered.
// Reset: count 0, sorted flag 1, previous key 0; key RAM is not cleared.
`default_nettype none

module sorted_table_binary_search import stbs_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = STBS_TABLE_DEPTH,
  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input wire logic clk,
  input wire logic rst,
  stbs_req_if.sink   req,
  stbs_rsp_if.source rsp
);

  logic             res_valid;
  logic             res_ready;
  stbs_res_t        res;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [KEY_W-1:0] wr_data;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic [KEY_W-1:0] rd_data;

  stbs_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  stbs_key_ram #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_key_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Output register: load when empty or when the held beat leaves this cycle.
  assign res_ready = !rsp.valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      rsp.position     <= res.position;
      rsp.found        <= res.found;
      rsp.table_sorted <= res.table_sorted;
      rsp.table_full   <= res.table_full;
    end
  end

endmodule

`default_nettype wire

// ===== verif/stbs_tb_pkg.sv =====
// Testbench package for the sorted key table: the scoreboard class that
// predicts each answer and checks the response beats. Depends on stbs_pkg.
`default_nettype none

package stbs_tb_pkg;
  import stbs_pkg::*;

  // The unused command code: the block answers it without changing the table.
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  class key_search_scoreboard;
    logic signed [KEY_W-1:0] key_mem [STBS_TABLE_DEPTH];
    int unsigned             key_total;
    bit                      ascending;
    logic signed [KEY_W-1:0] last_key;
    stbs_res_t               answers_due [$];
    int unsigned             failures;

    function new();
      key_total = 0;
      ascending = 1'b1;
      last_key  = '0;
      failures  = 0;
    endfunction

    // Binary search over the stored keys, midpoint rounded down.
    function automatic logic [POS_W-1:0] probe_search(input logic signed [KEY_W-1:0] k,
                                                      output bit hit);
      int lo;
      int hi;
      int mid;
      lo  = 0;
      hi  = int'(key_total) - 1;
      hit = 1'b0;
      while (lo <= hi) begin
        mid = (lo + hi) / 2;
        if (key_mem[mid] < k) begin
          lo = mid + 1;
        end else if (key_mem[mid] > k) begin
          hi = mid - 1;
        end else begin
          hit = 1'b1;
          return POS_W'(mid);
        end
      end
      return POS_W'(key_total);
    endfunction

    // Advance the predicted table by one accepted request beat.
    function void note_command(input logic [FUNC_W-1:0] f, input logic signed [KEY_W-1:0] k);
      stbs_res_t ans;
      bit        hit;
      ans = '0;
      case (f)
        FUNC_CLEAR: begin
          key_total = 0;
          ascending = 1'b1;
          last_key  = '0;
        end
        FUNC_APPEND: begin
          if (key_total >= STBS_TABLE_DEPTH) begin
            ans.table_full = 1'b1;
          end else begin
            if (key_total > 0 && last_key >= k) ascending = 1'b0;
            key_mem[key_total] = k;
            last_key = k;
            key_total++;
          end
        end
        default: ;
      endcase
      ans.position = POS_W'(key_total);
      if (f == FUNC_SEARCH) begin
        ans.position = probe_search(k, hit);
        ans.found    = hit;
      end
      ans.table_sorted = ascending;
      answers_due.push_back(ans);
    endfunction

    function void check_answer(input stbs_res_t got);
      stbs_res_t want;
      if (answers_due.size() == 0) begin
        $error("response beat with no request outstanding: position %0d", got.position);
        failures++;
        return;
      end
      want = answers_due.pop_front();
      if (got.position !== want.position) begin
        $error("position: expected %0d, actual %0d", want.position, got.position);
        failures++;
      end
      if (got.found !== want.found) begin
        $error("found: expected %0b, actual %0b", want.found, got.found);
        failures++;
      end
      if (got.table_sorted !== want.table_sorted) begin
        $error("table_sorted: expected %0b, actual %0b", want.table_sorted, got.table_sorted);
        failures++;
      end
      if (got.table_full !== want.table_full) begin
        $error("table_full: expected %0b, actual %0b", want.table_full, got.table_full);
        failures++;
      end
    endfunction

    function int unsigned pending();
      return answers_due.size();
    endfunction
  endclass

endpackage

`default_nettype wire

// ===== verif/testbench.sv =====
// Top-level testbench for sorted_table_binary_search: drives clear, append and
// search beats with random gaps and checks every response against the scoreboard.
// Depends on stbs_pkg, stbs_req_if, stbs_rsp_if and stbs_tb_pkg.
`default_nettype none

module testbench;
  import stbs_pkg::*;
  import stbs_tb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;
  localparam int unsigned RANDOM_ITEMS = 550;
  localparam int unsigned TAIL_CYCLES  = 40;
  localparam longint      TIMEOUT_NS   = 8_000_000;

  logic clk = 1'b0;
  logic rst;

  stbs_req_if req_ch ();
  stbs_rsp_if rsp_ch ();

  sorted_table_binary_search u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  key_search_scoreboard    board;
  logic signed [KEY_W-1:0] stored_keys [$];
  bit                      burst_mode;
  int unsigned             random_items;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly short gaps, a few long ones.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Send one request beat; returns at the edge where it was accepted.
  task automatic issue(input logic [FUNC_W-1:0] f, input logic signed [KEY_W-1:0] k);
    int unsigned gap;
    gap = burst_mode ? 0 : pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.func      <= f;
    req_ch.key_value <= k;
    do @(posedge clk); while (!req_ch.ready);
    board.note_command(f, k);
    case (f)
      FUNC_CLEAR: stored_keys.delete();
      FUNC_APPEND: if (stored_keys.size() < STBS_TABLE_DEPTH) stored_keys.push_back(k);
      default: ;
    endcase
    if (f != FUNC_UNUSED) random_items++;
  endtask

  // Hold the request side until every answer is back.
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  // Append n strictly ascending keys spread over about `spread` values.
  task automatic append_ascending(input int unsigned n, input longint spread);
    longint step;
    longint cur;
    step = spread / (n + 1);
    if (step < 1) step = 1;
    if (spread >= 64'sd2147483648) begin
      cur = -64'sd2147483648 + longint'($urandom_range(0, int'(step - 1)));
    end else begin
      cur = longint'($signed($urandom));
      if (cur + spread > 64'sd2147483647) cur -= spread;
    end
    repeat (n) begin
      issue(FUNC_APPEND, cur[KEY_W-1:0]);
      cur += 1 + longint'($urandom_range(0, int'(step - 1)));
    end
  endtask

  function automatic logic signed [KEY_W-1:0] search_target();
    int unsigned             r;
    logic signed [KEY_W-1:0] k;
    r = $urandom_range(0, 99);
    if (stored_keys.size() == 0 || r < 15) return $urandom;
    k = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
    if (r < 60) return k;
    if (r < 70) return k + 1;
    if (r < 80) return k - 1;
    if (r < 90) return ($urandom_range(0, 1) != 0) ? KEY_MAX : KEY_MIN;
    return $urandom;
  endfunction

  // Response side: random stalls with calm stretches in between.
  initial begin
    int unsigned stall_left;
    int unsigned rx_cycle;
    stall_left = 0;
    rx_cycle   = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rx_cycle++;
      if (stall_left != 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_ch.ready <= 1'b1;
        if ((rx_cycle % 600) >= 150 && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    stbs_res_t got;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got.position     = rsp_ch.position;
      got.found        = rsp_ch.found;
      got.table_sorted = rsp_ch.table_sorted;
      got.table_full   = rsp_ch.table_full;
      board.check_answer(got);
    end
  end

  initial begin
    #TIMEOUT_NS;
    $display("Verification failed");
    $finish;
  end

  initial begin
    int unsigned kind;
    int unsigned r;
    logic signed [KEY_W-1:0] k;
    board = new();
    burst_mode = 1'b0;
    random_items = 0;
    rst <= 1'b1;
    req_ch.valid     <= 1'b0;
    req_ch.func      <= FUNC_CLEAR;
    req_ch.key_value <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty table, extremes, misses, unused code, unsorted and
    // equal-neighbour tables, clear with stale entries, first key of zero.
    issue(FUNC_SEARCH, 32'sd0);
    issue(FUNC_UNUSED, 32'sd0);
    issue(FUNC_APPEND, KEY_MIN);
    issue(FUNC_APPEND, -32'sd1);
    issue(FUNC_APPEND, 32'sd0);
    issue(FUNC_APPEND, 32'sd1);
    issue(FUNC_APPEND, KEY_MAX);
    issue(FUNC_SEARCH, KEY_MIN);
    issue(FUNC_SEARCH, KEY_MAX);
    issue(FUNC_SEARCH, 32'sd0);
    issue(FUNC_SEARCH, 32'sd2);
    issue(FUNC_SEARCH, -32'sd2);
    issue(FUNC_UNUSED, KEY_MAX);
    issue(FUNC_APPEND, KEY_MAX);
    issue(FUNC_SEARCH, 32'sd1);
    issue(FUNC_APPEND, -32'sd5);
    issue(FUNC_SEARCH, 32'sd0);
    issue(FUNC_CLEAR, KEY_MAX);
    issue(FUNC_SEARCH, 32'sd0);
    issue(FUNC_APPEND, 32'sd5);
    issue(FUNC_APPEND, 32'sd5);
    issue(FUNC_SEARCH, 32'sd5);
    issue(FUNC_CLEAR, 32'sd0);
    issue(FUNC_APPEND, 32'sd0);
    issue(FUNC_SEARCH, 32'sd0);
    wait_drained();

    // Fill the table to capacity, then push past it.
    burst_mode = 1'b1;
    issue(FUNC_CLEAR, $urandom);
    burst_mode = ($urandom_range(0, 1) != 0);
    append_ascending(STBS_TABLE_DEPTH, 64'sd4294967296);
    burst_mode = 1'b0;
    repeat (3) issue(FUNC_APPEND, $urandom);
    issue(FUNC_SEARCH, stored_keys[0]);
    issue(FUNC_SEARCH, stored_keys[STBS_TABLE_DEPTH - 1]);
    issue(FUNC_SEARCH, stored_keys[STBS_TABLE_DEPTH / 2]);
    issue(FUNC_SEARCH, KEY_MAX);
    issue(FUNC_SEARCH, KEY_MIN);
    repeat (6) issue(FUNC_SEARCH, search_target());
    issue(FUNC_UNUSED, $urandom);
    issue(FUNC_APPEND, stored_keys[STBS_TABLE_DEPTH - 1]);
    wait_drained();

    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      burst_mode = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        if ($urandom_range(0, 4) != 0 || stored_keys.size() > 700) issue(FUNC_CLEAR, $urandom);
        r = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 24);
        if ($urandom_range(0, 1) != 0) append_ascending(r, 64'sd4294967296);
        else append_ascending(r, longint'(r) * $urandom_range(1, 4));
        repeat ($urandom_range(3, 12)) issue(FUNC_SEARCH, search_target());
      end else if (kind < 85) begin
        // Out-of-order and repeated keys.
        repeat ($urandom_range(2, 16)) begin
          r = $urandom_range(0, 99);
          if (stored_keys.size() != 0 && r < 30) k = stored_keys[$];
          else if (stored_keys.size() != 0 && r < 50) k = stored_keys[$] - $urandom_range(1, 8);
          else k = $urandom;
          issue(FUNC_APPEND, k);
        end
        repeat ($urandom_range(2, 8)) issue(FUNC_SEARCH, search_target());
      end else begin
        repeat ($urandom_range(4, 12)) begin
          r = $urandom_range(0, 3);
          issue(FUNC_W'(r), ($urandom_range(0, 1) != 0) ? search_target() : $urandom);
        end
      end
      if ($urandom_range(0, 5) == 0) wait_drained();
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.failures == 0 && board.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
